// ===== design/fwrl_pkg.sv =====
// Shared types, codes and constants of the fixed-window flow rate limiter.
package fwrl_pkg;

  localparam int unsigned FlowsDefault = 256;

  localparam logic [15:0] LimitReset  = 16'd60;
  localparam logic [15:0] WindowReset = 16'd60;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegRequestLimit  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWindowSeconds = 1'd1;

  typedef enum logic [1:0] {
    OP_CHECK   = 2'd0,
    OP_RECORD  = 2'd1,
    OP_CLEANUP = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_REDUCE,
    ST_LOOK,
    ST_WIN,
    ST_LIM,
    ST_SWEEP,
    ST_DRAIN,
    ST_CLEAR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] count;
    logic [31:0] start;
    logic [31:0] last;
  } entry_t;

  typedef struct packed {
    logic [31:0] diff;
    logic        borrow;
    logic        zero;
  } alu_res_t;

endpackage

// ===== design/fwrl_alu.sv =====
// Shared 32-bit subtract and compare unit of the rate limiter sequencer.
module fwrl_alu (
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output fwrl_pkg::alu_res_t res_o
);

  logic [32:0] diff;

  assign diff         = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff   = diff[31:0];
  assign res_o.borrow = diff[32];
  assign res_o.zero   = (diff[31:0] == 32'd0);

endmodule

// ===== design/fixed_window_flow_rate_limiter_unit.sv =====
// Top level of the per-flow fixed-window rate limiter with its flow table.
//
// Items come in on the in channel (opcode, flow_id, now_seconds) and each
// transfer yields exactly one result on the out channel (allowed, remaining,
// reset_seconds). An item is taken only while the sequencer is idle, so the
// block works on one item at a time. The flow table is one memory with a
// registered read port, and every entry goes through one shared subtractor.
// A check goes through ST_REDUCE and ST_LOOK and, for a live entry, on through
// ST_WIN and ST_LIM to ST_RESP; a record goes through ST_REDUCE and ST_LOOK to
// ST_RESP. The next item is taken once a result is loaded and the block is idle.
// When FLOWS is below 256, the flow index is reduced first by repeated
// subtraction of FLOWS, one subtraction per cycle.
// A cleanup reads one entry a cycle and then drains; a clear writes one entry a cycle.
// After reset the block clears the table in one pass over all FLOWS entries and holds
// in_stall_o high meanwhile; configuration writes are taken at any time.
// A result sits in an output register; while the receiver stalls, it holds,
// and a finished next item waits until that register is free.
module fixed_window_flow_rate_limiter_unit #(
  parameter int unsigned FLOWS = fwrl_pkg::FlowsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fwrl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [7:0]                   flow_id_i,
  input  logic [31:0]                  now_seconds_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         allowed_o,
  output logic [15:0]                  remaining_o,
  output logic [15:0]                  reset_seconds_o
);

  localparam int unsigned IdxW = $clog2(FLOWS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FLOWS - 1);

  fwrl_pkg::state_e  state_q, state_d;
  fwrl_pkg::opcode_e op_q, op_d;

  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [IdxW-1:0] prev_q, prev_d;
  logic            sweep_vld_q, sweep_vld_d;
  logic [7:0]      red_q, red_d;
  logic [31:0]     now_q, now_d;
  logic [31:0]     acc_q, acc_d;
  logic [15:0]     limit_q, window_q;

  logic            res_allowed_q, res_allowed_d;
  logic [15:0]     res_remaining_q, res_remaining_d;
  logic [15:0]     res_reset_q, res_reset_d;

  logic            out_valid_q, out_valid_d;
  logic            out_allowed_q;
  logic [15:0]     out_remaining_q, out_reset_q;
  logic            out_load;
  logic            out_free;

  logic [IdxW+7:0] red_ext;
  logic [IdxW-1:0] idx;
  logic            red_ge;

  fwrl_pkg::entry_t entry_mem [FLOWS];
  fwrl_pkg::entry_t rd_data_q;
  fwrl_pkg::entry_t mem_wd;
  logic [IdxW-1:0]  mem_wa;
  logic [IdxW-1:0]  rd_addr;
  logic             mem_we;

  logic [31:0]        alu_a, alu_b;
  fwrl_pkg::alu_res_t alu_res;
  logic [31:0]        idle_limit;

  fwrl_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign red_ext    = (IdxW + 8)'(red_q);
  assign idx        = red_ext[IdxW-1:0];
  assign red_ge     = (32'(red_q) >= 32'(FLOWS));
  assign idle_limit = {15'd0, window_q, 1'b0};
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != fwrl_pkg::ST_IDLE);

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    ptr_d           = ptr_q;
    prev_d          = prev_q;
    sweep_vld_d     = 1'b0;
    red_d           = red_q;
    now_d           = now_q;
    acc_d           = acc_q;
    res_allowed_d   = res_allowed_q;
    res_remaining_d = res_remaining_q;
    res_reset_d     = res_reset_q;
    mem_we          = 1'b0;
    mem_wa          = idx;
    mem_wd          = '0;
    rd_addr         = idx;
    alu_a           = '0;
    alu_b           = '0;
    out_load        = 1'b0;

    unique case (state_q) inside
      fwrl_pkg::ST_INIT, fwrl_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        if (ptr_q == LastIdx) begin
          ptr_d   = '0;
          state_d = (state_q == fwrl_pkg::ST_INIT) ? fwrl_pkg::ST_IDLE : fwrl_pkg::ST_RESP;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      fwrl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d            = fwrl_pkg::opcode_e'(opcode_i);
          red_d           = flow_id_i;
          now_d           = now_seconds_i;
          ptr_d           = '0;
          res_allowed_d   = 1'b0;
          res_remaining_d = '0;
          res_reset_d     = '0;
          unique case (fwrl_pkg::opcode_e'(opcode_i)) inside
            fwrl_pkg::OP_CHECK, fwrl_pkg::OP_RECORD: state_d = fwrl_pkg::ST_REDUCE;
            fwrl_pkg::OP_CLEANUP:                    state_d = fwrl_pkg::ST_SWEEP;
            fwrl_pkg::OP_CLEAR:                      state_d = fwrl_pkg::ST_CLEAR;
            default:                                 state_d = fwrl_pkg::ST_IDLE;
          endcase
        end
      end
      fwrl_pkg::ST_REDUCE: begin
        // The read of the reduced index issued here is consumed in ST_LOOK.
        if (red_ge) begin
          red_d = red_q - 8'(FLOWS);
        end else begin
          state_d = fwrl_pkg::ST_LOOK;
        end
      end
      fwrl_pkg::ST_LOOK: begin
        if (op_q == fwrl_pkg::OP_RECORD) begin
          mem_we = 1'b1;
          if (rd_data_q.valid) begin
            mem_wd.valid = 1'b1;
            mem_wd.count = (rd_data_q.count == 16'hFFFF) ? rd_data_q.count
                                                         : rd_data_q.count + 16'd1;
            mem_wd.start = rd_data_q.start;
            mem_wd.last  = now_q;
          end else begin
            mem_wd = '{valid: 1'b1, count: 16'd1, start: now_q, last: now_q};
          end
          state_d = fwrl_pkg::ST_RESP;
        end else if (!rd_data_q.valid) begin
          mem_we          = 1'b1;
          mem_wd          = '{valid: 1'b1, count: 16'd0, start: now_q, last: now_q};
          res_allowed_d   = 1'b1;
          res_remaining_d = limit_q;
          state_d         = fwrl_pkg::ST_RESP;
        end else begin
          alu_a   = now_q;
          alu_b   = rd_data_q.start;
          acc_d   = alu_res.diff;
          state_d = fwrl_pkg::ST_WIN;
        end
      end
      fwrl_pkg::ST_WIN: begin
        // Expired when the elapsed time reaches the window length.
        alu_a = {16'd0, window_q};
        alu_b = acc_q;
        if (alu_res.borrow || alu_res.zero) begin
          mem_we          = 1'b1;
          mem_wd          = '{valid: 1'b1, count: 16'd0, start: now_q, last: now_q};
          res_allowed_d   = 1'b1;
          res_remaining_d = limit_q;
          state_d         = fwrl_pkg::ST_RESP;
        end else begin
          res_reset_d = alu_res.diff[15:0];
          state_d     = fwrl_pkg::ST_LIM;
        end
      end
      fwrl_pkg::ST_LIM: begin
        alu_a = {16'd0, limit_q};
        alu_b = {16'd0, rd_data_q.count};
        if (!alu_res.borrow && !alu_res.zero) begin
          res_allowed_d   = 1'b1;
          res_remaining_d = alu_res.diff[15:0];
        end
        state_d = fwrl_pkg::ST_RESP;
      end
      fwrl_pkg::ST_SWEEP: begin
        rd_addr     = ptr_q;
        sweep_vld_d = 1'b1;
        prev_d      = ptr_q;
        if (ptr_q == LastIdx) begin
          state_d = fwrl_pkg::ST_DRAIN;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      fwrl_pkg::ST_DRAIN: begin
        state_d = fwrl_pkg::ST_RESP;
      end
      fwrl_pkg::ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = fwrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fwrl_pkg::ST_IDLE;
      end
    endcase

    // Cleanup: the entry read in the previous cycle is dropped when idle
    // for at least twice the window.
    if (sweep_vld_q) begin
      alu_a = now_q;
      alu_b = rd_data_q.last;
      if (rd_data_q.valid && (alu_res.diff >= idle_limit)) begin
        mem_we       = 1'b1;
        mem_wa       = prev_q;
        mem_wd       = rd_data_q;
        mem_wd.valid = 1'b0;
      end
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fwrl_pkg::ST_INIT;
      ptr_q       <= '0;
      sweep_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= fwrl_pkg::LimitReset;
      window_q    <= fwrl_pkg::WindowReset;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      sweep_vld_q <= sweep_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fwrl_pkg::RegRequestLimit:  limit_q  <= cfg_data_i;
          fwrl_pkg::RegWindowSeconds: window_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q            <= op_d;
    prev_q          <= prev_d;
    red_q           <= red_d;
    now_q           <= now_d;
    acc_q           <= acc_d;
    res_allowed_q   <= res_allowed_d;
    res_remaining_q <= res_remaining_d;
    res_reset_q     <= res_reset_d;
    if (out_load) begin
      out_allowed_q   <= res_allowed_q;
      out_remaining_q <= res_remaining_q;
      out_reset_q     <= res_reset_q;
    end
  end

  // Flow table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= entry_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign allowed_o       = out_allowed_q;
  assign remaining_o     = out_remaining_q;
  assign reset_seconds_o = out_reset_q;

`ifndef SYNTHESIS
  a_index_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fwrl_pkg::ST_LOOK) |-> (32'(red_q) < 32'(FLOWS)))
    else $error("flow index not reduced below the table size");

  a_sweep_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == fwrl_pkg::ST_SWEEP) && mem_we) |-> (mem_wa != rd_addr))
    else $error("cleanup writes the entry it is reading");

  a_limit_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fwrl_pkg::ST_LIM) |-> rd_data_q.valid)
    else $error("limit compare on an absent entry");

  a_denied_none_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !allowed_o) |-> (remaining_o == 16'd0))
    else $error("refused request reports remaining requests");
`endif

endmodule

// ===== tb/tb_fixed_window_flow_rate_limiter_unit.sv =====
// Self-checking testbench for the fixed-window flow rate limiter unit.
module tb_fixed_window_flow_rate_limiter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FLOWS       = fwrl_pkg::FlowsDefault;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_ITEMS = 220;

  typedef struct {
    fwrl_pkg::opcode_e op;
    logic [7:0]        flow;
    logic [31:0]       now;
  } flow_req_t;

  typedef struct packed {
    logic        allowed;
    logic [15:0] remaining;
    logic [15:0] reset_seconds;
  } verdict_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [fwrl_pkg::CfgIdxW-1:0] cfg_idx_i     = fwrl_pkg::RegRequestLimit;
  logic [15:0]                  cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   opcode_i      = fwrl_pkg::OP_CHECK;
  logic [7:0]                   flow_id_i     = '0;
  logic [31:0]                  now_seconds_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic                         allowed_o;
  logic [15:0]                  remaining_o;
  logic [15:0]                  reset_seconds_o;

  // Shadow copy of the flow table and of the two registers.
  bit          tbl_valid [FLOWS];
  logic [15:0] tbl_count [FLOWS];
  logic [31:0] tbl_start [FLOWS];
  logic [31:0] tbl_last  [FLOWS];
  logic [15:0] cfg_limit  = fwrl_pkg::LimitReset;
  logic [15:0] cfg_window = fwrl_pkg::WindowReset;

  flow_req_t   req_backlog[$];
  verdict_t    pending_verdicts[$];
  logic        in_taken = 1'b0;
  logic [31:0] cur_time = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_used = 1;
  int unsigned n_by_op [4];
  int unsigned n_allowed     = 0;

  fixed_window_flow_rate_limiter_unit #(.FLOWS(FLOWS)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .flow_id_i      (flow_id_i),
    .now_seconds_i  (now_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .allowed_o      (allowed_o),
    .remaining_o    (remaining_o),
    .reset_seconds_o(reset_seconds_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  function automatic void open_window(input int unsigned idx, input logic [15:0] cnt,
                                      input logic [31:0] now);
    tbl_valid[idx] = 1'b1;
    tbl_count[idx] = cnt;
    tbl_start[idx] = now;
    tbl_last[idx]  = now;
  endfunction

  // Computes the verdict of one transfer and applies its effect to the shadow table.
  function automatic verdict_t predict_verdict(input fwrl_pkg::opcode_e op,
                                               input logic [7:0] flow,
                                               input logic [31:0] now);
    verdict_t    v;
    int unsigned idx;
    logic [31:0] el;
    logic [31:0] w32;
    v   = '0;
    idx = int'(flow) % FLOWS;
    w32 = {16'd0, cfg_window};
    case (op)
      fwrl_pkg::OP_CHECK: begin
        if (!tbl_valid[idx]) begin
          v.allowed   = 1'b1;
          v.remaining = cfg_limit;
          open_window(idx, 16'd0, now);
        end else begin
          el = now - tbl_start[idx];
          if (el < w32) begin
            v.reset_seconds = cfg_window - el[15:0];
            v.allowed       = tbl_count[idx] < cfg_limit;
            v.remaining     = v.allowed ? cfg_limit - tbl_count[idx] : 16'd0;
          end else begin
            v.allowed   = 1'b1;
            v.remaining = cfg_limit;
            open_window(idx, 16'd0, now);
          end
        end
      end
      fwrl_pkg::OP_RECORD: begin
        if (!tbl_valid[idx]) begin
          open_window(idx, 16'd1, now);
        end else begin
          if (tbl_count[idx] != 16'hFFFF) tbl_count[idx] = tbl_count[idx] + 16'd1;
          tbl_last[idx] = now;
        end
      end
      fwrl_pkg::OP_CLEANUP: begin
        for (int i = 0; i < FLOWS; i++) begin
          el = now - tbl_last[i];
          if (tbl_valid[i] && el >= (w32 << 1)) tbl_valid[i] = 1'b0;
        end
      end
      default: begin
        for (int i = 0; i < FLOWS; i++) tbl_valid[i] = 1'b0;
      end
    endcase
    return v;
  endfunction

  // Driver: a new item goes out only once the previous one has been taken.
  always @(negedge clk_i) begin : drive_side
    flow_req_t req;
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    if (!in_valid_i || in_taken) begin
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = req_backlog.pop_front();
        in_valid_i    <= 1'b1;
        opcode_i      <= req.op;
        flow_id_i     <= req.flow;
        now_seconds_i <= req.now;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk_i) begin : check_side
    verdict_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      want = predict_verdict(fwrl_pkg::opcode_e'(opcode_i), flow_id_i, now_seconds_i);
      pending_verdicts.push_back(want);
      n_by_op[opcode_i]++;
      if (opcode_i == fwrl_pkg::OP_CHECK && want.allowed) n_allowed++;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result transfer with no item outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        if (allowed_o !== want.allowed)
          report_mismatch($sformatf("allowed %b, expected %b", allowed_o, want.allowed));
        if (remaining_o !== want.remaining)
          report_mismatch($sformatf("remaining %0d, expected %0d",
                                    remaining_o, want.remaining));
        if (reset_seconds_o !== want.reset_seconds)
          report_mismatch($sformatf("reset_seconds %0d, expected %0d",
                                    reset_seconds_o, want.reset_seconds));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_verdicts.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_item(input fwrl_pkg::opcode_e op, input logic [7:0] flow,
                          input logic [31:0] now);
    flow_req_t req;
    req.op   = op;
    req.flow = flow;
    req.now  = now;
    req_backlog.push_back(req);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || pending_verdicts.size() != 0);
  endtask

  // Both registers are written back to back; call only with the block idle.
  task automatic set_limits(input logic [15:0] lim, input logic [15:0] win);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fwrl_pkg::RegRequestLimit;
    cfg_data_i <= lim;
    @(negedge clk_i);
    cfg_idx_i  <= fwrl_pkg::RegWindowSeconds;
    cfg_data_i <= win;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_limit  = lim;
    cfg_window = win;
    settings_used++;
  endtask

  // Time advance that lands inside, on and past the window edges.
  function automatic logic [31:0] next_gap(input logic [31:0] w32);
    case ($urandom_range(0, 9))
      0: return w32;
      1: return (w32 != 0) ? w32 - 32'd1 : 32'd0;
      2: return w32 << 1;
      3: return $urandom;
      default: return $urandom_range(0, w32 / 3 + 1);
    endcase
  endfunction

  // Mostly bursts of records and checks on a few hot flows, with sweeps and noise mixed in.
  task automatic queue_traffic(input int unsigned n_items);
    int unsigned made;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  flow;
    logic [31:0] w32;
    made = 0;
    w32  = {16'd0, cfg_window};
    while (made < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        add_item(fwrl_pkg::opcode_e'($urandom_range(0, 3)), 8'($urandom), $urandom);
        made++;
      end else if (pick < 20) begin
        cur_time += next_gap(w32);
        add_item(fwrl_pkg::OP_CLEANUP, 8'($urandom), cur_time);
        made++;
      end else if (pick < 22) begin
        add_item(fwrl_pkg::OP_CLEAR, 8'($urandom), cur_time);
        made++;
      end else begin
        flow = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        len  = $urandom_range(2, ((int'(cfg_limit) < 6) ? int'(cfg_limit) : 6) + 3);
        repeat (len) begin
          cur_time += next_gap(w32);
          add_item(($urandom_range(0, 99) < 55) ? fwrl_pkg::OP_RECORD : fwrl_pkg::OP_CHECK,
                   flow, cur_time);
        end
        made += len;
      end
    end
  endtask

  initial begin
    logic [15:0] lim;
    logic [15:0] win;
    send_idle_pct = 19;
    recv_idle_pct = 87;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset settings of 60 requests per 60 seconds.
    add_item(fwrl_pkg::OP_CHECK,   8'h00, 32'd0);
    add_item(fwrl_pkg::OP_RECORD,  8'h00, 32'd1);
    add_item(fwrl_pkg::OP_CHECK,   8'h00, 32'd59);
    add_item(fwrl_pkg::OP_CHECK,   8'h00, 32'd60);
    add_item(fwrl_pkg::OP_RECORD,  8'hFF, 32'hFFFF_FFF0);
    add_item(fwrl_pkg::OP_RECORD,  8'hFF, 32'hFFFF_FFF8);
    add_item(fwrl_pkg::OP_CHECK,   8'hFF, 32'h0000_0010);
    add_item(fwrl_pkg::OP_RECORD,  8'hAA, 32'hAAAA_AAAA);
    add_item(fwrl_pkg::OP_CHECK,   8'h55, 32'h5555_5555);
    add_item(fwrl_pkg::OP_CHECK,   8'h55, 32'h5555_5555);
    add_item(fwrl_pkg::OP_CLEANUP, 8'hC3, 32'h0000_0080);
    add_item(fwrl_pkg::OP_CHECK,   8'hFF, 32'h0000_0080);
    add_item(fwrl_pkg::OP_CHECK,   8'h00, 32'h0000_0080);
    add_item(fwrl_pkg::OP_RECORD,  8'h01, 32'h0000_0081);
    add_item(fwrl_pkg::OP_CLEAR,   8'h5A, 32'hFFFF_FFFF);
    add_item(fwrl_pkg::OP_CHECK,   8'h00, 32'd0);
    add_item(fwrl_pkg::OP_CHECK,   8'h01, 32'h0000_0082);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (8) @(negedge clk_i);
      send_idle_pct = (ph < 3) ? 19 : (ph < 6) ? 87 : 0;
      recv_idle_pct = (ph < 3) ? 87 : (ph < 6) ? 19 : 0;
      case (ph)
        0:       begin lim = 16'd3;     win = 16'd10;    end
        1:       begin lim = 16'd0;     win = 16'd65535; end
        2:       begin lim = 16'd65535; win = 16'd1;     end
        3:       begin lim = 16'd1;     win = 16'd0;     end
        4:       begin lim = 16'd5;     win = 16'd20;    end
        5:       begin lim = 16'd2;     win = 16'd3;     end
        6:       begin lim = 16'd4;     win = 16'd65535; end
        7:       begin lim = 16'd7;     win = 16'd100;   end
        default: begin lim = 16'd65535; win = 16'd65535; end
      endcase
      set_limits(lim, win);
      cur_time = $urandom;
      queue_traffic(PHASE_ITEMS / 2);
      // Here the sender holds back until every result of the phase so far is in.
      if (ph == 1) wait_drained();
      queue_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    wait_drained();
    repeat (300) @(negedge clk_i);
    $display("covered %0d checks (%0d allowed), %0d records, %0d sweeps, %0d clears",
             n_by_op[fwrl_pkg::OP_CHECK], n_allowed, n_by_op[fwrl_pkg::OP_RECORD],
             n_by_op[fwrl_pkg::OP_CLEANUP], n_by_op[fwrl_pkg::OP_CLEAR]);
    $display("across %0d register settings: %0d results compared, %0d mismatches",
             settings_used, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
